@@ hw/rtl/bkq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bkq_pkg;

    // Field widths
    localparam int BUTTON_W = 11;
    localparam int STICK_W  = 8;
    localparam int FRAME_W  = 32;
    localparam int KEY_W    = 4;
    localparam int DIR_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int DELAY_W  = 8;
    localparam int LEVEL_W  = 7;
    localparam int ACTION_N = 7;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_NONE    = 4'd0;
    localparam logic [KEY_W-1:0] KEY_UP      = 4'd1;
    localparam logic [KEY_W-1:0] KEY_DOWN    = 4'd2;
    localparam logic [KEY_W-1:0] KEY_LEFT    = 4'd3;
    localparam logic [KEY_W-1:0] KEY_RIGHT   = 4'd4;
    localparam logic [KEY_W-1:0] KEY_CONFIRM = 4'd5;
    localparam logic [KEY_W-1:0] KEY_HELP    = 4'd11;

    // Button mask bit positions of the D-pad
    localparam int BTN_UP    = 7;
    localparam int BTN_DOWN  = 8;
    localparam int BTN_LEFT  = 9;
    localparam int BTN_RIGHT = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL    = 2'd3;

    // Register reset values
    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST   = 8'd18;
    localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = 8'd4;
    localparam logic [LEVEL_W-1:0] RELEASE_LEVEL_RST   = 7'd35;
    localparam logic [LEVEL_W-1:0] PRESS_LEVEL_RST     = 7'd55;

    typedef struct packed {
        logic [DELAY_W-1:0] initial_repeat_delay;
        logic [DELAY_W-1:0] repeat_interval;
        logic [LEVEL_W-1:0] stick_release_level;
        logic [LEVEL_W-1:0] stick_press_level;
    } cfg_t;

    // First direction in a mask, priority up, down, left, right
    function automatic logic [KEY_W-1:0] dir_of_mask(input logic [BUTTON_W-1:0] mask);
        logic [KEY_W-1:0] dir;
        dir = KEY_NONE;
        if (mask[BTN_UP]) begin
            dir = KEY_UP;
        end else if (mask[BTN_DOWN]) begin
            dir = KEY_DOWN;
        end else if (mask[BTN_LEFT]) begin
            dir = KEY_LEFT;
        end else if (mask[BTN_RIGHT]) begin
            dir = KEY_RIGHT;
        end
        return dir;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bkq_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bkq_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bkq_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [bkq_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output bkq_pkg::cfg_t                         cfg
);
    import bkq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_INITIAL_DELAY:   cfg_next.initial_repeat_delay = cfg_wr_data;
                REG_REPEAT_INTERVAL: cfg_next.repeat_interval = cfg_wr_data;
                REG_RELEASE_LEVEL:   cfg_next.stick_release_level = cfg_wr_data[LEVEL_W-1:0];
                REG_PRESS_LEVEL:     cfg_next.stick_press_level = cfg_wr_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_repeat_delay <= INITIAL_DELAY_RST;
            cfg_reg.repeat_interval      <= REPEAT_INTERVAL_RST;
            cfg_reg.stick_release_level  <= RELEASE_LEVEL_RST;
            cfg_reg.stick_press_level    <= PRESS_LEVEL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bkq_qualifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bkq_qualifier (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             advance,
    input  wire bkq_pkg::cfg_t                    cfg,
    input  wire logic [bkq_pkg::BUTTON_W-1:0]     pressed_buttons,
    input  wire logic [bkq_pkg::BUTTON_W-1:0]     held_buttons,
    input  wire logic signed [bkq_pkg::STICK_W-1:0] stick_horizontal,
    input  wire logic signed [bkq_pkg::STICK_W-1:0] stick_vertical,
    input  wire logic [bkq_pkg::FRAME_W-1:0]      frame_count,
    output logic [bkq_pkg::KEY_W-1:0]             key_code
);
    import bkq_pkg::*;

    logic                 stick_latched_reg;
    logic                 stick_latched_next;
    logic [DIR_W-1:0]     repeat_dir_reg;
    logic [DIR_W-1:0]     repeat_dir_next;
    logic [FRAME_W-1:0]   next_frame_reg;
    logic [FRAME_W-1:0]   next_frame_next;

    logic [BUTTON_W-1:0]  any_buttons;
    logic                 action_found;
    logic [KEY_W-1:0]     action_code;
    logic [KEY_W-1:0]     dir_pressed;
    logic [KEY_W-1:0]     dir_held;
    logic [FRAME_W-1:0]   frame_plus_delay;
    logic [FRAME_W-1:0]   frame_plus_interval;
    logic [FRAME_W-1:0]   frame_diff;
    logic signed [STICK_W:0] sx;
    logic signed [STICK_W:0] sy;
    logic signed [STICK_W:0] rel;
    logic signed [STICK_W:0] prs;
    logic                 stick_centred;
    logic                 check_stick;
    logic                 latched_eff;

    // Find the highest-priority action button, A first
    always_comb begin
        any_buttons  = pressed_buttons | held_buttons;
        action_found = 1'b0;
        action_code  = KEY_NONE;
        for (int b = ACTION_N - 1; b >= 0; b--) begin
            if (any_buttons[b]) begin
                action_found = 1'b1;
                action_code  = KEY_CONFIRM + KEY_W'(b);
            end
        end
    end

    assign dir_pressed = dir_of_mask(pressed_buttons);
    assign dir_held    = dir_of_mask(held_buttons);

    // Arm times and the wrapping due compare
    assign frame_plus_delay    = frame_count + FRAME_W'(cfg.initial_repeat_delay);
    assign frame_plus_interval = frame_count + FRAME_W'(cfg.repeat_interval);
    assign frame_diff          = frame_count - next_frame_reg;

    // Widen the stick values by one bit so that the negated levels fit
    assign sx  = {stick_horizontal[STICK_W-1], stick_horizontal};
    assign sy  = {stick_vertical[STICK_W-1], stick_vertical};
    assign rel = $signed({2'b00, cfg.stick_release_level});
    assign prs = $signed({2'b00, cfg.stick_press_level});

    assign stick_centred = (sx > -rel) && (sx < rel) && (sy > -rel) && (sy < rel);

    // Pick the key and the next state
    always_comb begin
        key_code           = KEY_NONE;
        stick_latched_next = stick_latched_reg;
        repeat_dir_next    = repeat_dir_reg;
        next_frame_next    = next_frame_reg;
        check_stick        = 1'b0;
        latched_eff        = stick_latched_reg;

        if (action_found) begin
            key_code = action_code;
        end else if (dir_pressed != KEY_NONE) begin
            repeat_dir_next = dir_pressed[DIR_W-1:0];
            next_frame_next = frame_plus_delay;
            key_code        = dir_pressed;
        end else if (dir_held == KEY_NONE) begin
            repeat_dir_next = '0;
            check_stick     = 1'b1;
        end else if (dir_held != {1'b0, repeat_dir_reg}) begin
            repeat_dir_next = dir_held[DIR_W-1:0];
            next_frame_next = frame_plus_delay;
            key_code        = dir_held;
        end else if (!frame_diff[FRAME_W-1]) begin
            next_frame_next = frame_plus_interval;
            key_code        = dir_held;
        end else begin
            check_stick = 1'b1;
        end

        // Stick latch with hysteresis
        if (check_stick) begin
            if (stick_centred) begin
                latched_eff = 1'b0;
            end
            stick_latched_next = latched_eff;
            if (!latched_eff) begin
                if (sy > prs) begin
                    stick_latched_next = 1'b1;
                    key_code           = KEY_UP;
                end else if (sy < -prs) begin
                    stick_latched_next = 1'b1;
                    key_code           = KEY_DOWN;
                end else if (sx < -prs) begin
                    stick_latched_next = 1'b1;
                    key_code           = KEY_LEFT;
                end else if (sx > prs) begin
                    stick_latched_next = 1'b1;
                    key_code           = KEY_RIGHT;
                end
            end
        end
    end

    // Commit the state as the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_latched_reg <= 1'b0;
            repeat_dir_reg    <= '0;
            next_frame_reg    <= '0;
        end else if (advance) begin
            stick_latched_reg <= stick_latched_next;
            repeat_dir_reg    <= repeat_dir_next;
            next_frame_reg    <= next_frame_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/button_key_qualifier_autorepeat_top.sv @@
// Button key qualifier with typematic auto-repeat.
//
// Input channel (s_valid/s_ready): one controller poll per transfer, with
// the pressed and held button masks, both stick axes and the frame count.
// Result channel (m_valid/m_ready): exactly one key code per poll, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into the register chosen by
// cfg_wr_index (0 initial delay, 1 repeat interval, 2 release level,
// 3 press level) at the clock edge; write only while the block is idle.
//
// The poll is held in an input register, qualified combinationally against
// the repeat and stick-latch state, and the code lands in the result
// register while the state is updated. Throughput: one poll per cycle
// while the result register can drain (m_ready high or result empty).
//
// Reset (aresetn low, synchronous) empties both registers, clears the
// repeat and latch state and restores the register defaults.
// When the receiver stalls, the result holds; one more poll is still taken
// into the input register, after which s_ready drops until m_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module button_key_qualifier_autorepeat_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bkq_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [bkq_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [bkq_pkg::BUTTON_W-1:0]       s_pressed_buttons,
    input  wire logic [bkq_pkg::BUTTON_W-1:0]       s_held_buttons,
    input  wire logic signed [bkq_pkg::STICK_W-1:0] s_stick_horizontal,
    input  wire logic signed [bkq_pkg::STICK_W-1:0] s_stick_vertical,
    input  wire logic [bkq_pkg::FRAME_W-1:0]        s_frame_count,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [bkq_pkg::KEY_W-1:0]               m_key_code
);
    import bkq_pkg::*;

    cfg_t cfg;

    logic                     in_valid_reg;
    logic [BUTTON_W-1:0]      pressed_reg;
    logic [BUTTON_W-1:0]      held_reg;
    logic signed [STICK_W-1:0] stick_h_reg;
    logic signed [STICK_W-1:0] stick_v_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic                     out_valid_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [KEY_W-1:0]         key_next;
    logic                     advance;
    logic                     in_take;

    bkq_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Move the held poll on when the result register is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    bkq_qualifier u_qualifier (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .cfg              (cfg),
        .pressed_buttons  (pressed_reg),
        .held_buttons     (held_reg),
        .stick_horizontal (stick_h_reg),
        .stick_vertical   (stick_v_reg),
        .frame_count      (frame_reg),
        .key_code         (key_next)
    );

    // Input register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge aclk) begin
        if (in_take) begin
            pressed_reg <= s_pressed_buttons;
            held_reg    <= s_held_buttons;
            stick_h_reg <= s_stick_horizontal;
            stick_v_reg <= s_stick_vertical;
            frame_reg   <= s_frame_count;
        end
    end

    // Result register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register: payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            key_reg <= key_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_key_code = key_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bkq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bkq_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic [bkq_pkg::KEY_W-1:0]      m_key_code
);
    import bkq_pkg::*;

    // A result only ever carries a defined key code
    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_key_code <= KEY_HELP))
        else $error("key code out of range");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key_code))
        else $error("stalled result changed");

    // With the result side empty the block takes a poll
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A result appearing from empty comes from a transfer through the input register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transfer");

endmodule

bind button_key_qualifier_autorepeat_top bkq_checker u_bkq_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_key_code (m_key_code)
);

`default_nettype wire
